[rtl/core/short_name_path_component_converter_defines.svh]
// Assertion macros for the short-name path converter checkers.
`ifndef SHORT_NAME_PATH_COMPONENT_CONVERTER_DEFINES_SVH
`define SHORT_NAME_PATH_COMPONENT_CONVERTER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define SCNC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked only while a result is offered.
`define SCNC_ASSERT_OUT(label, cond, msg) \
	`SCNC_ASSERT(label, m_tvalid |-> (cond), msg)

`endif

[rtl/core/scnc_pkg.sv]
package scnc_pkg;

	localparam int MAX_COMPONENT_LEN_DEF = 255;

	localparam int BYTE_W   = 8;
	localparam int BASE_LEN = 8;
	localparam int EXT_LEN  = 3;
	localparam int NAME_LEN = BASE_LEN + EXT_LEN;
	localparam int LEN_W    = 8;
	localparam int LEN_MAX  = 255;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	// result bit layout in m_tdata
	localparam int STATUS_W   = 2;
	localparam int BASE_W     = BASE_LEN * BYTE_W;
	localparam int EXT_W      = EXT_LEN * BYTE_W;
	localparam int STATUS_LSB = 0;
	localparam int BASE_LSB   = STATUS_LSB + STATUS_W;
	localparam int EXT_LSB    = BASE_LSB + BASE_W;
	localparam int LEN_LSB    = EXT_LSB + EXT_W;
	localparam int OUT_BITS   = LEN_LSB + LEN_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic       forbidden;
		logic       alnum;
		logic [7:0] upper;
	} char_info_t;

endpackage

[rtl/core/scnc_char_map.sv]
module scnc_char_map (
	input  logic [7:0]              ch,
	output scnc_pkg::char_info_t    info
);

	always_comb begin
		info.forbidden = ch inside {8'h22, 8'h2A, [8'h2B:8'h2F], [8'h3A:8'h3F],
			[8'h5B:8'h5D], [8'h7C:8'h7E]};
		info.alnum = ch inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]};
		if (ch inside {[8'h61:8'h7A]}) begin
			info.upper = ch - 8'h20;
		end else begin
			info.upper = ch;
		end
	end

endmodule

[rtl/core/short_name_path_component_converter.sv]
// A terminator byte (slash or NUL) goes through the input register, then the result register,
// which offers it on m_tvalid; while a result stalls, it waits in the input register.
// Throughput: one byte per cycle; a stalled result stops a terminator and the bytes behind it.
// Reset: arst_n clears the component state (name all spaces, counters zero) and
// both valid flags; no clearing pass is needed.
module short_name_path_component_converter #(
	parameter int MAX_COMPONENT_LEN = scnc_pkg::MAX_COMPONENT_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] path_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] status, [65:2] name_base, [89:66] name_ext, [97:90] component_length
	output logic [scnc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int CNT_W = $clog2(MAX_COMPONENT_LEN + 1);

	logic       v_s1;
	logic [7:0] byte_s1;

	logic [7:0]       name_q [scnc_pkg::NAME_LEN];
	logic [CNT_W-1:0] count_q;
	logic             dot_seen_q;
	logic [1:0]       ext_pos_q;
	logic             bad_q;
	logic [7:0]       first_q;
	logic [7:0]       second_q;

	logic out_valid_q;
	logic [scnc_pkg::OUT_TDATA_W-1:0] out_data_q;

	scnc_pkg::char_info_t info;
	logic is_term;
	logic adv;
	logic out_free;

	scnc_pkg::status_t status;
	logic [scnc_pkg::BASE_W-1:0] base_word;
	logic [scnc_pkg::EXT_W-1:0]  ext_word;
	logic [scnc_pkg::LEN_W-1:0]  len_sat;

	scnc_char_map u_char_map (
		.ch   (byte_s1),
		.info (info)
	);

	assign is_term  = (byte_s1 == scnc_pkg::CH_NUL) || (byte_s1 == scnc_pkg::CH_SLASH);
	assign out_free = !out_valid_q || m_tready;
	assign adv      = v_s1 && (!is_term || out_free);
	assign s_tready = !v_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// result of a terminator
	always_comb begin
		logic is_dot1;
		logic is_dot2;
		is_dot1 = (32'(count_q) == 1) && (first_q == scnc_pkg::CH_DOT);
		is_dot2 = (32'(count_q) == 2) && (first_q == scnc_pkg::CH_DOT)
			&& (second_q == scnc_pkg::CH_DOT);
		base_word = '0;
		ext_word  = '0;
		if (count_q == '0) begin
			status = scnc_pkg::STATUS_EMPTY;
		end else if (is_dot1 || is_dot2) begin
			status = scnc_pkg::STATUS_OK;
		end else if (first_q == scnc_pkg::CH_DOT || bad_q) begin
			status = scnc_pkg::STATUS_INVALID;
		end else begin
			status = scnc_pkg::STATUS_OK;
		end
		if (is_dot1) begin
			base_word = {scnc_pkg::CH_DOT, {(scnc_pkg::BASE_LEN-1){scnc_pkg::CH_SPACE}}};
			ext_word  = {scnc_pkg::EXT_LEN{scnc_pkg::CH_SPACE}};
		end else if (is_dot2) begin
			base_word = {scnc_pkg::CH_DOT, scnc_pkg::CH_DOT,
				{(scnc_pkg::BASE_LEN-2){scnc_pkg::CH_SPACE}}};
			ext_word  = {scnc_pkg::EXT_LEN{scnc_pkg::CH_SPACE}};
		end else if (status == scnc_pkg::STATUS_OK) begin
			for (int i = 0; i < scnc_pkg::BASE_LEN; i++) begin
				base_word[(scnc_pkg::BASE_LEN-1-i)*8 +: 8] = name_q[i];
			end
			for (int i = 0; i < scnc_pkg::EXT_LEN; i++) begin
				ext_word[(scnc_pkg::EXT_LEN-1-i)*8 +: 8] = name_q[scnc_pkg::BASE_LEN + i];
			end
		end
		if (32'(count_q) > scnc_pkg::LEN_MAX) begin
			len_sat = scnc_pkg::LEN_W'(scnc_pkg::LEN_MAX);
		end else begin
			len_sat = scnc_pkg::LEN_W'(count_q);
		end
	end

	// component state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scnc_pkg::NAME_LEN; i++) begin
				name_q[i] <= scnc_pkg::CH_SPACE;
			end
			count_q    <= '0;
			dot_seen_q <= 1'b0;
			ext_pos_q  <= '0;
			bad_q      <= 1'b0;
			first_q    <= '0;
			second_q   <= '0;
		end else if (adv) begin
			if (is_term) begin
				for (int i = 0; i < scnc_pkg::NAME_LEN; i++) begin
					name_q[i] <= scnc_pkg::CH_SPACE;
				end
				count_q    <= '0;
				dot_seen_q <= 1'b0;
				ext_pos_q  <= '0;
				bad_q      <= 1'b0;
				first_q    <= '0;
				second_q   <= '0;
			end else begin
				if (count_q == '0) begin
					first_q <= byte_s1;
				end else if (32'(count_q) == 1) begin
					second_q <= byte_s1;
				end
				if (!dot_seen_q) begin
					if (byte_s1 == scnc_pkg::CH_DOT) begin
						dot_seen_q <= 1'b1;
						ext_pos_q  <= '0;
					end else if (32'(count_q) < scnc_pkg::BASE_LEN) begin
						if (info.forbidden) begin
							bad_q <= 1'b1;
						end else begin
							name_q[4'(count_q[2:0])] <= info.upper;
						end
					end
				end else if (32'(ext_pos_q) < scnc_pkg::EXT_LEN) begin
					if (info.alnum) begin
						name_q[4'(scnc_pkg::BASE_LEN) + 4'(ext_pos_q)] <= info.upper;
					end else begin
						bad_q <= 1'b1;
					end
					ext_pos_q <= ext_pos_q + 2'd1;
				end
				if (32'(count_q) < MAX_COMPONENT_LEN) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_term) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_term) begin
			out_data_q <= scnc_pkg::OUT_TDATA_W'({len_sat, ext_word, base_word,
				status});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[rtl/core/scnc_checker.sv]
`include "short_name_path_component_converter_defines.svh"

module scnc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [scnc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic [1:0] st;
	logic [7:0] len;
	logic [scnc_pkg::BASE_W+scnc_pkg::EXT_W-1:0] name;

	assign st   = m_tdata[scnc_pkg::STATUS_LSB +: scnc_pkg::STATUS_W];
	assign len  = m_tdata[scnc_pkg::LEN_LSB +: scnc_pkg::LEN_W];
	assign name = m_tdata[scnc_pkg::BASE_LSB +: scnc_pkg::BASE_W + scnc_pkg::EXT_W];

	`SCNC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`SCNC_ASSERT_OUT(a_status_code, st != 2'd3, "undefined status code")
	`SCNC_ASSERT_OUT(a_empty_zero, st != scnc_pkg::STATUS_EMPTY || (len == '0 && name == '0), "empty component with data")
	`SCNC_ASSERT_OUT(a_invalid_name, st != scnc_pkg::STATUS_INVALID || (name == '0 && len != '0), "invalid name not cleared")
	`SCNC_ASSERT_OUT(a_ok_len, st != scnc_pkg::STATUS_OK || len != '0, "valid name with zero length")

endmodule

bind short_name_path_component_converter scnc_checker u_scnc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[dv/tb.sv]
module tb;

	localparam int MAX_LEN = scnc_pkg::MAX_COMPONENT_LEN_DEF;

	typedef struct {
		scnc_pkg::status_t status;
		logic [63:0]       name_base;
		logic [23:0]       name_ext;
		logic [7:0]        comp_len;
	} short_name_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [scnc_pkg::OUT_TDATA_W-1:0] m_tdata;

	logic [7:0]  path_bytes[$];
	short_name_t expected_names[$];

	// component state of the predictor
	logic [7:0] comp_name[scnc_pkg::NAME_LEN];
	int         comp_count;
	logic       comp_dot;
	int         comp_ext_pos;
	logic       comp_bad;
	logic [7:0] comp_first;
	logic [7:0] comp_second;

	int   send_gap_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic byte_taken = 1'b0;
	int   phase_bytes = 0;
	int   errors = 0;

	short_name_path_component_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic illegal_base_char(input logic [7:0] c);
		return c == 8'h22 || c == 8'h2A || (c >= 8'h2B && c <= 8'h2F) ||
			(c >= 8'h3A && c <= 8'h3F) || (c >= 8'h5B && c <= 8'h5D) ||
			(c >= 8'h7C && c <= 8'h7E);
	endfunction

	function automatic logic ext_char_ok(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	task clear_component();
		for (int i = 0; i < scnc_pkg::NAME_LEN; i++)
			comp_name[i] = scnc_pkg::CH_SPACE;
		comp_count = 0;
		comp_dot = 1'b0;
		comp_ext_pos = 0;
		comp_bad = 1'b0;
		comp_first = '0;
		comp_second = '0;
	endtask

	task take_path_byte(input logic [7:0] c);
		short_name_t r;
		if (c != scnc_pkg::CH_NUL && c != scnc_pkg::CH_SLASH) begin
			if (comp_count == 0)
				comp_first = c;
			else if (comp_count == 1)
				comp_second = c;
			if (!comp_dot) begin
				if (c == scnc_pkg::CH_DOT) begin
					comp_dot = 1'b1;
					comp_ext_pos = 0;
				end else if (comp_count < scnc_pkg::BASE_LEN) begin
					if (illegal_base_char(c))
						comp_bad = 1'b1;
					else
						comp_name[comp_count] = upcase(c);
				end
			end else if (comp_ext_pos < scnc_pkg::EXT_LEN) begin
				if (ext_char_ok(c))
					comp_name[scnc_pkg::BASE_LEN + comp_ext_pos] = upcase(c);
				else
					comp_bad = 1'b1;
				comp_ext_pos++;
			end
			if (comp_count < MAX_LEN)
				comp_count++;
		end else begin
			r.name_base = '0;
			r.name_ext = '0;
			r.comp_len = 8'((comp_count > scnc_pkg::LEN_MAX) ? scnc_pkg::LEN_MAX : comp_count);
			if (comp_count == 0) begin
				r.status = scnc_pkg::STATUS_EMPTY;
			end else if (comp_count == 1 && comp_first == scnc_pkg::CH_DOT) begin
				for (int i = 0; i < scnc_pkg::NAME_LEN; i++)
					comp_name[i] = scnc_pkg::CH_SPACE;
				comp_name[0] = scnc_pkg::CH_DOT;
				r.status = scnc_pkg::STATUS_OK;
			end else if (comp_count == 2 && comp_first == scnc_pkg::CH_DOT &&
				comp_second == scnc_pkg::CH_DOT) begin
				for (int i = 0; i < scnc_pkg::NAME_LEN; i++)
					comp_name[i] = scnc_pkg::CH_SPACE;
				comp_name[0] = scnc_pkg::CH_DOT;
				comp_name[1] = scnc_pkg::CH_DOT;
				r.status = scnc_pkg::STATUS_OK;
			end else if (comp_first == scnc_pkg::CH_DOT || comp_bad) begin
				r.status = scnc_pkg::STATUS_INVALID;
			end else begin
				r.status = scnc_pkg::STATUS_OK;
			end
			if (r.status == scnc_pkg::STATUS_OK) begin
				for (int i = 0; i < scnc_pkg::BASE_LEN; i++)
					r.name_base = {r.name_base[55:0], comp_name[i]};
				for (int i = scnc_pkg::BASE_LEN; i < scnc_pkg::NAME_LEN; i++)
					r.name_ext = {r.name_ext[15:0], comp_name[i]};
			end
			expected_names.push_back(r);
			clear_component();
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			if (path_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				s_tdata <= path_bytes.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin
		short_name_t e;
		logic [1:0]  got_status;
		logic [63:0] got_base;
		logic [23:0] got_ext;
		logic [7:0]  got_len;
		byte_taken = s_tvalid && s_tready;
		if (byte_taken)
			take_path_byte(s_tdata);
		if (m_tvalid && m_tready) begin
			got_status = m_tdata[scnc_pkg::STATUS_LSB +: scnc_pkg::STATUS_W];
			got_base = m_tdata[scnc_pkg::BASE_LSB +: scnc_pkg::BASE_W];
			got_ext = m_tdata[scnc_pkg::EXT_LSB +: scnc_pkg::EXT_W];
			got_len = m_tdata[scnc_pkg::LEN_LSB +: scnc_pkg::LEN_W];
			if (expected_names.size() == 0) begin
				$error("unexpected result: status %0h base %0h ext %0h length %0d",
					got_status, got_base, got_ext, got_len);
				errors++;
			end else begin
				e = expected_names.pop_front();
				if (got_status !== e.status) begin
					$error("status: expected %0h, got %0h", e.status, got_status);
					errors++;
				end
				if (got_base !== e.name_base) begin
					$error("name_base: expected %h, got %h", e.name_base, got_base);
					errors++;
				end
				if (got_ext !== e.name_ext) begin
					$error("name_ext: expected %h, got %h", e.name_ext, got_ext);
					errors++;
				end
				if (got_len !== e.comp_len) begin
					$error("component_length: expected %0d, got %0d", e.comp_len, got_len);
					errors++;
				end
			end
		end
	end

	task push_byte(input logic [7:0] b);
		path_bytes.push_back(b);
		phase_bytes++;
	endtask

	function automatic logic [7:0] rand_base_char();
		logic [7:0] c;
		if ($urandom_range(1) == 0)
			return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + $urandom_range(25));
		do
			c = 8'($urandom_range(1, 255));
		while (illegal_base_char(c) || c == scnc_pkg::CH_DOT);
		return c;
	endfunction

	function automatic logic [7:0] rand_ext_char();
		int r;
		r = $urandom_range(61);
		if (r < 26)
			return 8'(8'h41 + r);
		if (r < 52)
			return 8'(8'h61 + r - 26);
		return 8'(8'h30 + r - 52);
	endfunction

	function automatic logic [7:0] rand_terminator();
		return $urandom_range(1) ? scnc_pkg::CH_SLASH : scnc_pkg::CH_NUL;
	endfunction

	function automatic logic [7:0] rand_noise_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == scnc_pkg::CH_SLASH);
		return c;
	endfunction

	// one component: mostly well-formed names, then noise, dot entries and empties
	task push_component();
		int kind;
		int n_base;
		int n_ext;
		int spoil;
		int k;
		logic [7:0] word[$];
		kind = $urandom_range(99);
		if (kind < 65 || kind >= 90) begin
			n_base = $urandom_range(1, 10);
			for (int i = 0; i < n_base; i++)
				word.push_back(rand_base_char());
			if ($urandom_range(9) < 7) begin
				word.push_back(scnc_pkg::CH_DOT);
				n_ext = $urandom_range(0, 4);
				for (int i = 0; i < n_ext; i++)
					word.push_back(rand_ext_char());
				if ($urandom_range(19) == 0)
					word.push_back(scnc_pkg::CH_DOT);
			end
			if (kind >= 90) begin
				spoil = $urandom_range(word.size() - 1);
				word[spoil] = rand_noise_char();
			end
		end else if (kind < 78) begin
			k = $urandom_range(1, 12);
			for (int i = 0; i < k; i++)
				word.push_back(rand_noise_char());
		end else if (kind < 84) begin
			k = $urandom_range(1, 4);
			for (int i = 0; i < k; i++)
				word.push_back((i < 2 || $urandom_range(1)) ? scnc_pkg::CH_DOT :
					rand_ext_char());
		end
		foreach (word[i])
			push_byte(word[i]);
		push_byte(rand_terminator());
	endtask

	// around the length limit, so the count may saturate
	task push_long_component();
		int n;
		n = $urandom_range(250, 262);
		for (int i = 0; i < n; i++)
			push_byte((i == 5) ? scnc_pkg::CH_DOT :
				((i < 5) ? rand_base_char() : rand_noise_char()));
		push_byte(rand_terminator());
	endtask

	task wait_drained();
		while (path_bytes.size() > 0 || s_tvalid || expected_names.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [7:0] directed[22] = '{
			8'h2F,
			8'h2E, 8'h2F,
			8'h2E, 8'h2E, 8'h2F,
			8'h2E, 8'h2E, 8'h2E, 8'h00,
			8'h61, 8'hFF, 8'h2E, 8'h62, 8'h31, 8'h2F,
			8'h78, 8'h2A, 8'h2E, 8'h63, 8'h2F,
			8'h00
		};
		int gap_tab[4] = '{0, 63, 0, 34};
		int stall_tab[4] = '{0, 0, 63, 34};
		clear_component();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			push_byte(directed[i]);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = gap_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 0)
				hold_req = 1'b1;
			phase_bytes = 0;
			if (ph % 2 == 1)
				push_long_component();
			while (phase_bytes < 470)
				push_component();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_names.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/scnc_pkg.sv
rtl/core/scnc_char_map.sv
rtl/core/short_name_path_component_converter.sv
rtl/core/scnc_checker.sv
dv/tb.sv
